[rtl/lmbp_pkg.sv]
package lmbp_pkg;

  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_BLINK    = 2'd1,
    CMD_SET_MODE = 2'd2,
    CMD_AUTO_OFF = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_PWM   = 2'd3
  } led_mode_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_HIGH  = 2'd0,
    REG_PWM_PERIOD   = 2'd1,
    REG_DUTY_PERCENT = 2'd2,
    REG_DEFAULT_MODE = 2'd3
  } cfg_reg_t;

  localparam logic        ACTIVE_HIGH_RST  = 1'b1;
  localparam logic [15:0] PWM_PERIOD_RST   = 16'd1000;
  localparam logic [6:0]  DUTY_PERCENT_RST = 7'd50;
  localparam logic [6:0]  DUTY_MAX         = 7'd100;
  localparam logic [22:0] PWM_SCALE        = 23'd100;
  localparam logic [31:0] NEVER_STAMP      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        active_high;
    logic [15:0] pwm_period;
    logic [6:0]  duty_percent;
    logic [1:0]  default_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  new_mode;
    logic [31:0] duration;
  } in_beat_t;

  typedef struct packed {
    logic       pin_level;
    logic       pin_written;
    logic [1:0] current_mode;
  } out_beat_t;

endpackage

[rtl/lmbp_cfg.sv]
module lmbp_cfg import lmbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACTIVE_HIGH:  cfg_next.active_high  = cfg_data[0];
        REG_PWM_PERIOD:   cfg_next.pwm_period   = cfg_data[15:0];
        REG_DUTY_PERCENT: cfg_next.duty_percent = cfg_data[6:0];
        REG_DEFAULT_MODE: cfg_next.default_mode = cfg_data[1:0];
        default:          cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high  <= ACTIVE_HIGH_RST;
      cfg.pwm_period   <= PWM_PERIOD_RST;
      cfg.duty_percent <= DUTY_PERCENT_RST;
      cfg.default_mode <= MODE_OFF;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

[rtl/lmbp_step.sv]
module lmbp_step import lmbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_beat_t  item,
  input  cfg_t      cfg,
  output out_beat_t res
);

  logic [31:0] time_now, time_now_next;
  logic [15:0] pwm_phase, pwm_phase_next;
  led_mode_t   led_mode, led_mode_next;
  logic        last_level, last_level_next;
  logic        level_known, level_known_next;
  logic [31:0] blink_start, blink_start_next;
  logic [31:0] blink_length, blink_length_next;
  logic [31:0] off_stamp, off_stamp_next;
  logic        pin_reg, pin_reg_next;

  logic [15:0] per;
  logic [6:0]  duty_sat;
  logic [16:0] phase_inc;
  logic [15:0] phase_wrap;
  logic [22:0] duty_prod;
  logic [22:0] phase_scaled;
  logic [31:0] time_inc;
  logic [31:0] blink_age;
  logic        level;
  logic        written;

  assign per          = (cfg.pwm_period == '0) ? 16'd1 : cfg.pwm_period;
  assign duty_sat     = (cfg.duty_percent > DUTY_MAX) ? DUTY_MAX : cfg.duty_percent;
  assign phase_inc    = {1'b0, pwm_phase} + 17'd1;
  assign phase_wrap   = (phase_inc >= {1'b0, per}) ? '0 : phase_inc[15:0];
  assign duty_prod    = 23'(per) * 23'(duty_sat);
  assign phase_scaled = 23'(phase_wrap) * PWM_SCALE;
  assign time_inc     = time_now + 32'd1;
  assign blink_age    = time_inc - blink_start;

  always_comb begin
    time_now_next     = time_now;
    pwm_phase_next    = pwm_phase;
    led_mode_next     = led_mode;
    last_level_next   = last_level;
    level_known_next  = level_known;
    blink_start_next  = blink_start;
    blink_length_next = blink_length;
    off_stamp_next    = off_stamp;
    pin_reg_next      = pin_reg;
    level             = 1'b0;
    written           = 1'b0;
    unique case (cmd_t'(item.mode))
      CMD_TICK: begin
        time_now_next  = time_inc;
        pwm_phase_next = phase_wrap;
        unique case (led_mode)
          MODE_OFF: level = 1'b0;
          MODE_ON:  level = 1'b1;
          MODE_BLINK: begin
            if (blink_length < blink_age) begin
              level         = 1'b0;
              led_mode_next = led_mode_t'(cfg.default_mode);
            end else begin
              level = 1'b1;
            end
          end
          MODE_PWM: level = (phase_scaled <= duty_prod);
          default:  level = 1'b0;
        endcase
        if (!level_known || (last_level != level)) begin
          written      = 1'b1;
          pin_reg_next = level ^ !cfg.active_high;
        end
        last_level_next  = level;
        level_known_next = 1'b1;
        if (off_stamp < time_inc) begin
          led_mode_next = MODE_OFF;
        end
      end
      CMD_BLINK: begin
        if (item.duration != '0) begin
          blink_start_next  = time_now;
          blink_length_next = item.duration;
          led_mode_next     = MODE_BLINK;
          pin_reg_next      = cfg.active_high;
          last_level_next   = 1'b1;
          level_known_next  = 1'b1;
          written           = 1'b1;
        end
      end
      CMD_SET_MODE: led_mode_next = led_mode_t'(item.new_mode);
      CMD_AUTO_OFF: begin
        off_stamp_next = (item.duration == NEVER_STAMP) ? NEVER_STAMP
                                                        : time_now + item.duration;
      end
      default: led_mode_next = led_mode;
    endcase
  end

  assign res.pin_level    = pin_reg_next;
  assign res.pin_written  = written;
  assign res.current_mode = led_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now     <= '0;
      pwm_phase    <= '0;
      led_mode     <= MODE_OFF;
      last_level   <= 1'b0;
      level_known  <= 1'b0;
      blink_start  <= '0;
      blink_length <= '0;
      off_stamp    <= NEVER_STAMP;
      pin_reg      <= 1'b0;
    end else if (fire) begin
      time_now     <= time_now_next;
      pwm_phase    <= pwm_phase_next;
      led_mode     <= led_mode_next;
      last_level   <= last_level_next;
      level_known  <= level_known_next;
      blink_start  <= blink_start_next;
      blink_length <= blink_length_next;
      off_stamp    <= off_stamp_next;
      pin_reg      <= pin_reg_next;
    end
  end

endmodule

[rtl/led_mode_blink_pwm_controller_core.sv]
// Single LED channel controller: off, on, blink and software PWM modes.
// Input channel (in_valid/in_ready/in_beat) carries one command per beat:
// millisecond tick, blink start, mode change or auto-off arm. Output channel
// (out_valid/out_ready/out_beat) returns exactly one beat per input beat, in
// order: the pin level, whether the pin was written, and the mode after it.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the block is idle, which the block does not
// enforce; index 0 polarity, 1 PWM period, 2 duty, 3 default mode. A beat is
// captured in the input register, the next state and the result are worked
// out combinationally, and the result register presents it: out_valid rises
// when the beat advances into it. One beat per cycle sustained while the
// receiver accepts, set by the combinational state update between registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; in_ready drops only while both are full.
// Reset (rst, synchronous) empties both registers, restores register defaults,
// clears time and phase, sets mode off and makes the first tick write the pin.
module led_mode_blink_pwm_controller_core import lmbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_beat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_beat,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_beat_t  s_beat;
  logic      s_valid;
  logic      advance;
  out_beat_t res;

  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || advance;

  lmbp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmbp_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (s_beat),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_beat <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat <= res;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s_valid |-> in_ready)
    else $error("input stage empty but in_ready low");

  a_result_after_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat did not reach the result register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s_valid && !advance |=> s_valid && $stable(s_beat))
    else $error("input stage lost a beat while stalled");

endmodule

[verif/led_ctrl_checker.sv]
`timescale 1ns / 100ps
module led_ctrl_checker import lmbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_beat_t              in_beat,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_beat_t             out_beat,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    n_pending,
  output int                    n_fail
);

  localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

  cfg_t        cfg;
  logic [31:0] time_now;
  logic [31:0] blink_start;
  logic [31:0] blink_len;
  logic [31:0] off_stamp;
  logic [15:0] pwm_phase;
  led_mode_t   led_mode;
  logic [1:0]  last_level;
  logic        pin_reg;
  out_beat_t   led_status_q[$];
  out_beat_t   head;

  function automatic out_beat_t apply_command(in_beat_t b);
    logic [16:0] per;
    logic [6:0]  duty;
    logic [31:0] thr;
    logic        level;
    logic        written;
    out_beat_t   r;
    written = 1'b0;
    case (cmd_t'(b.mode))
      CMD_TICK: begin
        per  = (cfg.pwm_period == '0) ? 17'd1 : {1'b0, cfg.pwm_period};
        duty = (cfg.duty_percent > DUTY_MAX) ? DUTY_MAX : cfg.duty_percent;
        time_now = time_now + 32'd1;
        if ({1'b0, pwm_phase} + 17'd1 >= per) pwm_phase = '0;
        else pwm_phase = pwm_phase + 16'd1;
        case (led_mode)
          MODE_OFF: level = 1'b0;
          MODE_ON: level = 1'b1;
          MODE_BLINK: begin
            if (blink_len < time_now - blink_start) begin
              level = 1'b0;
              led_mode = led_mode_t'(cfg.default_mode);
            end else begin
              level = 1'b1;
            end
          end
          default: begin
            thr = (32'(per) * 32'(duty)) / 32'(PWM_SCALE);
            level = (32'(pwm_phase) <= thr);
          end
        endcase
        if (last_level != {1'b0, level}) begin
          pin_reg = cfg.active_high ? level : ~level;
          written = 1'b1;
        end
        last_level = {1'b0, level};
        if (off_stamp < time_now) led_mode = MODE_OFF;
      end
      CMD_BLINK: begin
        if (b.duration != '0) begin
          blink_start = time_now;
          blink_len   = b.duration;
          led_mode    = MODE_BLINK;
          pin_reg     = cfg.active_high;
          last_level  = 2'd1;
          written     = 1'b1;
        end
      end
      CMD_SET_MODE: led_mode = led_mode_t'(b.new_mode);
      default: begin
        off_stamp = (b.duration == NEVER_STAMP) ? NEVER_STAMP : time_now + b.duration;
      end
    endcase
    r.pin_level    = pin_reg;
    r.pin_written  = written;
    r.current_mode = led_mode;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.active_high  = ACTIVE_HIGH_RST;
      cfg.pwm_period   = PWM_PERIOD_RST;
      cfg.duty_percent = DUTY_PERCENT_RST;
      cfg.default_mode = MODE_OFF;
      time_now    = '0;
      pwm_phase   = '0;
      led_mode    = MODE_OFF;
      last_level  = LEVEL_UNKNOWN;
      blink_start = '0;
      blink_len   = '0;
      off_stamp   = NEVER_STAMP;
      pin_reg     = 1'b0;
      led_status_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (led_status_q.size() == 0) begin
          $error("result beat with no command outstanding");
          n_fail++;
        end else begin
          head = led_status_q.pop_front();
          if (out_beat.pin_level !== head.pin_level) begin
            $error("pin_level: expected %0d, got %0d", head.pin_level, out_beat.pin_level);
            n_fail++;
          end
          if (out_beat.pin_written !== head.pin_written) begin
            $error("pin_written: expected %0d, got %0d", head.pin_written,
                   out_beat.pin_written);
            n_fail++;
          end
          if (out_beat.current_mode !== head.current_mode) begin
            $error("current_mode: expected %0d, got %0d", head.current_mode,
                   out_beat.current_mode);
            n_fail++;
          end
        end
      end
      if (in_valid && in_ready) led_status_q.push_back(apply_command(in_beat));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ACTIVE_HIGH: cfg.active_high = cfg_data[0];
          REG_PWM_PERIOD: cfg.pwm_period = cfg_data[15:0];
          REG_DUTY_PERCENT: cfg.duty_percent = cfg_data[6:0];
          default: cfg.default_mode = cfg_data[1:0];
        endcase
      end
    end
    n_pending = led_status_q.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
module tb;
  import lmbp_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_beat_t              in_beat = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = REG_ACTIVE_HIGH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    n_pending;
  int                    n_fail;
  int                    stall_cycles = 0;
  int                    hold_reqs = 0;
  int                    hold_served = 0;
  logic [31:0]           ticks_sent = '0;
  bit                    idle_on = 1'b1;

  always #1 clk = ~clk;

  led_mode_blink_pwm_controller_core i_dut (.*);

  led_ctrl_checker i_checker (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** led_mode_blink_pwm_controller_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random back-pressure plus long hold-offs on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_served < hold_reqs) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= !idle_on || ($urandom_range(99) >= 23);
    end
  end

  task automatic send_command(in_beat_t b);
    while (idle_on && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    if (b.mode == CMD_TICK) ticks_sent++;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic issue(cmd_t c, led_mode_t m, logic [31:0] d);
    in_beat_t b;
    b.mode     = c;
    b.new_mode = m;
    b.duration = d;
    send_command(b);
  endtask

  task automatic program_regs(logic ah, logic [15:0] per, logic [6:0] duty, led_mode_t dm);
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACTIVE_HIGH;
    cfg_data  <= CFG_DATA_W'(ah);
    @(negedge clk);
    cfg_index <= REG_PWM_PERIOD;
    cfg_data  <= per;
    @(negedge clk);
    cfg_index <= REG_DUTY_PERCENT;
    cfg_data  <= CFG_DATA_W'(duty);
    @(negedge clk);
    cfg_index <= REG_DEFAULT_MODE;
    cfg_data  <= CFG_DATA_W'(dm);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_beat_t random_command();
    in_beat_t b;
    int       pick;
    int       sel;
    b.new_mode = 2'($urandom_range(3));
    b.duration = $urandom();
    pick = $urandom_range(99);
    sel  = $urandom_range(19);
    if (pick < 58) begin
      b.mode = CMD_TICK;
    end else if (pick < 70) begin
      b.mode = CMD_BLINK;
      if (sel < 2) b.duration = '0;
      else if (sel < 14) b.duration = $urandom_range(1, 30);
      else if (sel == 14) b.duration = NEVER_STAMP;
      else if (sel < 18) b.duration = $urandom_range(31, 2000);
    end else if (pick < 85) begin
      b.mode = CMD_SET_MODE;
    end else begin
      b.mode = CMD_AUTO_OFF;
      if (sel < 8) b.duration = NEVER_STAMP;
      else if (sel < 14) b.duration = $urandom_range(40);
      else if (sel == 17) b.duration = NEVER_STAMP - ticks_sent;
      else if (sel > 17) b.duration = $urandom_range(200, 5000);
    end
    return b;
  endfunction

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_TICK, MODE_PWM, NEVER_STAMP);
    issue(CMD_SET_MODE, MODE_ON, '0);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_SET_MODE, MODE_PWM, NEVER_STAMP);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_SET_MODE, MODE_OFF, '0);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_BLINK, MODE_OFF, '0);
    issue(CMD_BLINK, MODE_OFF, 32'd2);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_SET_MODE, MODE_BLINK, '0);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_AUTO_OFF, MODE_OFF, NEVER_STAMP);
    issue(CMD_AUTO_OFF, MODE_OFF, 32'd2);
    issue(CMD_SET_MODE, MODE_ON, '0);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_AUTO_OFF, MODE_OFF, NEVER_STAMP - ticks_sent);
    issue(CMD_SET_MODE, MODE_ON, '0);
    issue(CMD_TICK, MODE_OFF, '0);
    issue(CMD_AUTO_OFF, MODE_OFF, NEVER_STAMP);

    for (int p = 1; p <= N_PHASES; p++) begin
      case (p)
        1: program_regs(1'b0, 16'd7, 7'd50, MODE_PWM);
        2: program_regs(1'b1, 16'd1, 7'd0, MODE_ON);
        3: program_regs(1'b0, 16'd65535, 7'd100, MODE_BLINK);
        4: program_regs(1'b1, 16'd10, 7'd101, MODE_PWM);
        5: program_regs(1'b1, 16'd0, 7'd127, MODE_OFF);
        default: program_regs(1'($urandom_range(1)),
                              ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 20)),
                              7'($urandom_range(127)), led_mode_t'($urandom_range(3)));
      endcase
      idle_on = (p != 3);
      if (p == 2 || p == 6) begin
        @(posedge clk);
        hold_reqs++;
        @(negedge clk);
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_command(random_command());
    end

    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_fail == 0) begin
      $display("** led_mode_blink_pwm_controller_core: PASSED **");
    end else begin
      $display("** led_mode_blink_pwm_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lmbp_pkg.sv
rtl/lmbp_cfg.sv
rtl/lmbp_step.sv
rtl/led_mode_blink_pwm_controller_core.sv
verif/led_ctrl_checker.sv
verif/tb.sv
